>>> src/lsbx_pkg.sv
// Shared types and constants for the LSB message extractor.
package lsbx_pkg;

  localparam int HEADER_BITS = 16;
  localparam int FIELD_W     = 16;
  localparam int BYTE_BITS   = 8;
  localparam int BIT_CNT_W   = $clog2(HEADER_BITS + 1);

  typedef enum logic [2:0] {
    PH_INTERVAL = 3'd0,
    PH_PLEN     = 3'd1,
    PH_SIZE     = 3'd2,
    PH_PATH     = 3'd3,
    PH_TEXT     = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PATH   = 2'd1,
    KIND_TEXT   = 2'd2
  } kind_t;

  // Word held in the input register, passed to the extractor.
  typedef struct packed {
    logic valid;
    logic lsb;
  } step_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data_byte;
    logic [FIELD_W-1:0] path_length;
    logic [FIELD_W-1:0] text_size;
    logic [FIELD_W-1:0] sample_interval;
    logic               last;
  } result_t;

endpackage

>>> src/lsbx_in_stage.sv
// Input register for incoming pixel words.
module lsbx_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    pixel,
  input  logic          pixel_valid,
  output logic          pixel_ready,
  input  logic          advance,
  output lsbx_pkg::step_t step
);

  logic in_valid;
  logic in_lsb;

  assign pixel_ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (pixel_valid && pixel_ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_valid && pixel_ready) begin
      in_lsb <= pixel[0];
    end
  end

  assign step.valid = in_valid;
  assign step.lsb   = in_lsb;

endmodule

>>> src/lsbx_extract.sv
// Message decode state and result register.
module lsbx_extract (
  input  logic              clk,
  input  logic              rst,
  input  lsbx_pkg::step_t   step,
  output logic              advance,
  output lsbx_pkg::result_t result,
  output logic              result_valid,
  input  logic              result_ready
);

  localparam int FW = lsbx_pkg::FIELD_W;
  localparam int BW = lsbx_pkg::BIT_CNT_W;

  lsbx_pkg::phase_t phase, phase_next;
  logic [BW-1:0]    bit_count, bit_count_next;
  logic [FW-1:0]    shift_reg, shift_reg_next;
  logic [FW-1:0]    skip_count, skip_count_next;
  logic [FW-1:0]    interval_reg, interval_reg_next;
  logic [FW-1:0]    path_len_reg, path_len_reg_next;
  logic [FW-1:0]    size_reg, size_reg_next;
  logic [FW-1:0]    byte_count, byte_count_next;

  logic [FW-1:0]    shifted;
  logic [BW-1:0]    bc_inc;
  logic [FW-1:0]    byte_inc;
  logic [FW-1:0]    skip_reload;
  logic             header_full;
  logic             byte_full;
  logic             sample;
  logic             res_fire;
  lsbx_pkg::result_t res;

  assign advance     = step.valid && (!result_valid || result_ready);
  assign shifted     = {shift_reg[FW-2:0], step.lsb};
  assign bc_inc      = bit_count + BW'(1);
  assign byte_inc    = byte_count + FW'(1);
  assign header_full = bc_inc >= BW'(lsbx_pkg::HEADER_BITS);
  assign byte_full   = bc_inc >= BW'(lsbx_pkg::BYTE_BITS);
  assign skip_reload = (interval_reg == '0) ? '0 : interval_reg - FW'(1);
  assign sample      = (skip_count == '0);

  // next state
  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_reg_next    = shift_reg;
    skip_count_next   = skip_count;
    interval_reg_next = interval_reg;
    path_len_reg_next = path_len_reg;
    size_reg_next     = size_reg;
    byte_count_next   = byte_count;
    unique case (phase)
      lsbx_pkg::PH_INTERVAL: begin
        shift_reg_next = shifted;
        bit_count_next = bc_inc;
        if (header_full) begin
          interval_reg_next = shifted;
          shift_reg_next    = '0;
          bit_count_next    = '0;
          skip_count_next   = '0;
          phase_next        = lsbx_pkg::PH_PLEN;
        end
      end
      lsbx_pkg::PH_PLEN, lsbx_pkg::PH_SIZE, lsbx_pkg::PH_PATH, lsbx_pkg::PH_TEXT: begin
        if (!sample) begin
          skip_count_next = skip_count - FW'(1);
        end else begin
          skip_count_next = skip_reload;
          shift_reg_next  = shifted;
          bit_count_next  = bc_inc;
          if (phase == lsbx_pkg::PH_PLEN) begin
            if (header_full) begin
              path_len_reg_next = shifted;
              shift_reg_next    = '0;
              bit_count_next    = '0;
              phase_next        = lsbx_pkg::PH_SIZE;
            end
          end else if (phase == lsbx_pkg::PH_SIZE) begin
            if (header_full) begin
              size_reg_next   = shifted;
              shift_reg_next  = '0;
              bit_count_next  = '0;
              byte_count_next = '0;
              if (path_len_reg != '0) begin
                phase_next = lsbx_pkg::PH_PATH;
              end else if (shifted != '0) begin
                phase_next = lsbx_pkg::PH_TEXT;
              end else begin
                phase_next = lsbx_pkg::PH_DONE;
              end
            end
          end else if (byte_full) begin
            shift_reg_next  = '0;
            bit_count_next  = '0;
            byte_count_next = byte_inc;
            if (phase == lsbx_pkg::PH_PATH) begin
              if (byte_inc == path_len_reg) begin
                byte_count_next = '0;
                phase_next = (size_reg != '0) ? lsbx_pkg::PH_TEXT : lsbx_pkg::PH_DONE;
              end
            end else if (byte_inc == size_reg) begin
              byte_count_next = '0;
              phase_next      = lsbx_pkg::PH_DONE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result
  always_comb begin
    res_fire            = 1'b0;
    res.kind            = lsbx_pkg::KIND_HEADER;
    res.data_byte       = '0;
    res.path_length     = path_len_reg;
    res.text_size       = size_reg;
    res.sample_interval = interval_reg;
    res.last            = (phase_next == lsbx_pkg::PH_DONE);
    unique case (phase)
      lsbx_pkg::PH_SIZE: begin
        res_fire      = sample && header_full;
        res.text_size = shifted;
      end
      lsbx_pkg::PH_PATH: begin
        res_fire      = sample && byte_full;
        res.kind      = lsbx_pkg::KIND_PATH;
        res.data_byte = shifted[7:0];
      end
      lsbx_pkg::PH_TEXT: begin
        res_fire      = sample && byte_full;
        res.kind      = lsbx_pkg::KIND_TEXT;
        res.data_byte = shifted[7:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= lsbx_pkg::PH_INTERVAL;
      bit_count    <= '0;
      shift_reg    <= '0;
      skip_count   <= '0;
      interval_reg <= '0;
      path_len_reg <= '0;
      size_reg     <= '0;
      byte_count   <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_reg    <= shift_reg_next;
      skip_count   <= skip_count_next;
      interval_reg <= interval_reg_next;
      path_len_reg <= path_len_reg_next;
      size_reg     <= size_reg_next;
      byte_count   <= byte_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && res_fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_fire) begin
      result <= res;
    end
  end

endmodule

>>> src/lsb_message_extractor_unit.sv
// Top level of the LSB message extractor.
// Pixel words arrive in raster order and one is taken every cycle as long
// as results are taken; each word is held in the input register and then
// decoded into the result register. The first 16 pixels give the sampling
// interval (0 acts as 1), then every interval-th pixel supplies one bit of
// path length, text size, path bytes and text bytes, MSB first. A header
// word follows the text size, then one word per recovered byte; last marks
// the final word, after which pixels are consumed and dropped until reset.
module lsb_message_extractor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  pixel,
  input  logic        pixel_valid,
  output logic        pixel_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] path_length,
  output logic [15:0] text_size,
  output logic [15:0] sample_interval,
  output logic        last,
  output logic        result_valid,
  input  logic        result_ready
);

  lsbx_pkg::step_t   step;
  lsbx_pkg::result_t result;
  logic              advance;

  lsbx_in_stage u_in_stage (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .advance     (advance),
    .step        (step)
  );

  lsbx_extract u_extract (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .advance      (advance),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  assign kind            = result.kind;
  assign data_byte       = result.data_byte;
  assign path_length     = result.path_length;
  assign text_size       = result.text_size;
  assign sample_interval = result.sample_interval;
  assign last            = result.last;

endmodule
